// File: rtl/lswc_pkg.sv
package lswc_pkg;

  localparam int COORD_W   = 16;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_MOVES = 8;
  localparam int MOVE_CNT_W = $clog2(MAX_MOVES + 1);
  localparam int DIV_STEPS = DIFF_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BOTTOM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd3;

  localparam logic [1:0] STATUS_INSIDE    = 2'd0;
  localparam logic [1:0] STATUS_CLIPPED   = 2'd1;
  localparam logic [1:0] STATUS_INVISIBLE = 2'd2;

  localparam int CODE_LEFT   = 0;
  localparam int CODE_RIGHT  = 1;
  localparam int CODE_BOTTOM = 2;
  localparam int CODE_TOP    = 3;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } in_req_t;

  typedef struct packed {
    logic [1:0]                clip_status;
    logic signed [COORD_W-1:0] clipped_start_x;
    logic signed [COORD_W-1:0] clipped_start_y;
    logic signed [COORD_W-1:0] clipped_end_x;
    logic signed [COORD_W-1:0] clipped_end_y;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LOOP,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       setup;
    logic       mul;
    logic       div_step;
    logic       update;
    logic       finish;
    logic [1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic win_valid;
    logic start_in;
    logic end_in;
    logic overlap;
  } dp_stat_t;

endpackage

// File: rtl/lswc_ctrl.sv
module lswc_ctrl
  import lswc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t                state_r, state_nxt;
  logic [MOVE_CNT_W-1:0] move_cnt_r, move_cnt_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;
  logic                  out_valid_r;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    move_cnt_nxt = move_cnt_r;
    div_cnt_nxt  = div_cnt_r;
    case (state_r)
      ST_IDLE: begin
        move_cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_FIRST;
        end
      end
      ST_FIRST: begin
        if (!stat.win_valid || (stat.start_in && stat.end_in)) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_LOOP;
        end
      end
      ST_LOOP: begin
        if (stat.overlap || (stat.start_in && stat.end_in) ||
            (move_cnt_r == MOVE_CNT_W'(MAX_MOVES))) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        div_cnt_nxt = '0;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        move_cnt_nxt = move_cnt_r + 1'b1;
        state_nxt    = ST_LOOP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.status = STATUS_INVISIBLE;
    case (state_r)
      ST_IDLE: begin
        cmd.load = start;
      end
      ST_FIRST: begin
        if (!stat.win_valid) begin
          cmd.finish = 1'b1;
          cmd.status = STATUS_INVISIBLE;
        end else if (stat.start_in && stat.end_in) begin
          cmd.finish = 1'b1;
          cmd.status = STATUS_INSIDE;
        end
      end
      ST_LOOP: begin
        if (stat.overlap) begin
          cmd.finish = 1'b1;
          cmd.status = STATUS_INVISIBLE;
        end else if (stat.start_in && stat.end_in) begin
          cmd.finish = 1'b1;
          cmd.status = STATUS_CLIPPED;
        end else if (move_cnt_r == MOVE_CNT_W'(MAX_MOVES)) begin
          cmd.finish = 1'b1;
          cmd.status = STATUS_INVISIBLE;
        end
      end
      ST_SETUP:  cmd.setup    = 1'b1;
      ST_MUL:    cmd.mul      = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_UPDATE: cmd.update   = 1'b1;
      default:   cmd.finish   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      move_cnt_r  <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      move_cnt_r  <= move_cnt_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= cmd.finish;
    end
  end

endmodule

// File: rtl/lswc_dp.sv
module lswc_dp
  import lswc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  in_req_t              in_req,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output out_rsp_t             out_rsp
);

  logic signed [COORD_W-1:0] win_left_r, win_bottom_r, win_right_r, win_top_r;
  logic signed [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [3:0]                c0, c1, c_sel;
  logic                      first;
  logic signed [COORD_W-1:0] xo, yo, xi, yi, edge_val;
  logic                      horiz;

  logic                      first_r, horiz_r, neg_r, zdiv_r;
  logic signed [COORD_W-1:0] edge_r, base_r;
  logic signed [DIFF_W-1:0]  d_r, e_r, f_r;
  logic [DIFF_W-1:0]         ad, ae, af;
  logic [2*DIFF_W-1:0]       prod;

  logic [DIFF_W-1:0]         rem_r, rem_nxt, low_r, low_nxt, dvsr_r, quo;
  logic [DIFF_W:0]           trial, diff;
  logic                      ge;
  logic signed [DIFF_W:0]    base_x, quo_x, sum;
  logic signed [COORD_W-1:0] new_c;

  out_rsp_t                  out_rsp_r;

  function automatic logic [3:0] region(
    input logic signed [COORD_W-1:0] x,
    input logic signed [COORD_W-1:0] y,
    input logic signed [COORD_W-1:0] wl,
    input logic signed [COORD_W-1:0] wb,
    input logic signed [COORD_W-1:0] wr,
    input logic signed [COORD_W-1:0] wt
  );
    logic [3:0] c;
    c = '0;
    c[CODE_LEFT]   = (x < wl);
    c[CODE_RIGHT]  = (x > wr);
    c[CODE_BOTTOM] = (y < wb);
    c[CODE_TOP]    = (y > wt);
    return c;
  endfunction

  assign c0 = region(x0_r, y0_r, win_left_r, win_bottom_r, win_right_r, win_top_r);
  assign c1 = region(x1_r, y1_r, win_left_r, win_bottom_r, win_right_r, win_top_r);

  assign stat.win_valid = (win_left_r <= win_right_r) && (win_bottom_r <= win_top_r);
  assign stat.start_in  = (c0 == 4'd0);
  assign stat.end_in    = (c1 == 4'd0);
  assign stat.overlap   = ((c0 & c1) != 4'd0);

  // move the start point while it is outside, else the end point
  assign first = (c0 != 4'd0);
  assign c_sel = first ? c0 : c1;
  assign xo    = first ? x0_r : x1_r;
  assign yo    = first ? y0_r : y1_r;
  assign xi    = first ? x1_r : x0_r;
  assign yi    = first ? y1_r : y0_r;
  assign horiz = c_sel[CODE_TOP] | c_sel[CODE_BOTTOM];

  always_comb begin
    if (c_sel[CODE_TOP]) begin
      edge_val = win_top_r;
    end else if (c_sel[CODE_BOTTOM]) begin
      edge_val = win_bottom_r;
    end else if (c_sel[CODE_RIGHT]) begin
      edge_val = win_right_r;
    end else begin
      edge_val = win_left_r;
    end
  end

  assign ad   = d_r[DIFF_W-1] ? DIFF_W'(-d_r) : DIFF_W'(d_r);
  assign ae   = e_r[DIFF_W-1] ? DIFF_W'(-e_r) : DIFF_W'(e_r);
  assign af   = f_r[DIFF_W-1] ? DIFF_W'(-f_r) : DIFF_W'(f_r);
  assign prod = {{DIFF_W{1'b0}}, ad} * {{DIFF_W{1'b0}}, ae};

  // restoring divider, one quotient bit per step
  assign trial   = {rem_r, low_r[DIFF_W-1]};
  assign diff    = trial - {1'b0, dvsr_r};
  assign ge      = (trial >= {1'b0, dvsr_r});
  assign rem_nxt = ge ? diff[DIFF_W-1:0] : trial[DIFF_W-1:0];
  assign low_nxt = {low_r[DIFF_W-2:0], ge};

  assign quo    = zdiv_r ? '0 : low_r;
  assign base_x = (DIFF_W+1)'(base_r);
  assign quo_x  = signed'({1'b0, quo});
  assign sum    = neg_r ? (base_x - quo_x) : (base_x + quo_x);
  assign new_c  = sum[COORD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= '0;
      win_bottom_r <= '0;
      win_right_r  <= COORD_W'(639);
      win_top_r    <= COORD_W'(479);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LEFT:   win_left_r   <= cfg_wdata;
        REG_WINDOW_BOTTOM: win_bottom_r <= cfg_wdata;
        REG_WINDOW_RIGHT:  win_right_r  <= cfg_wdata;
        REG_WINDOW_TOP:    win_top_r    <= cfg_wdata;
        default:           win_left_r   <= win_left_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r <= in_req.start_x;
      y0_r <= in_req.start_y;
      x1_r <= in_req.end_x;
      y1_r <= in_req.end_y;
    end else if (cmd.update) begin
      if (first_r) begin
        x0_r <= horiz_r ? new_c : edge_r;
        y0_r <= horiz_r ? edge_r : new_c;
      end else begin
        x1_r <= horiz_r ? new_c : edge_r;
        y1_r <= horiz_r ? edge_r : new_c;
      end
    end

    if (cmd.setup) begin
      first_r <= first;
      horiz_r <= horiz;
      edge_r  <= edge_val;
      if (horiz) begin
        base_r <= xo;
        d_r    <= DIFF_W'(xi) - DIFF_W'(xo);
        e_r    <= DIFF_W'(edge_val) - DIFF_W'(yo);
        f_r    <= DIFF_W'(yi) - DIFF_W'(yo);
      end else begin
        base_r <= yo;
        d_r    <= DIFF_W'(yi) - DIFF_W'(yo);
        e_r    <= DIFF_W'(edge_val) - DIFF_W'(xo);
        f_r    <= DIFF_W'(xi) - DIFF_W'(xo);
      end
    end

    if (cmd.mul) begin
      rem_r  <= prod[2*DIFF_W-1:DIFF_W];
      low_r  <= prod[DIFF_W-1:0];
      dvsr_r <= af;
      neg_r  <= d_r[DIFF_W-1] ^ e_r[DIFF_W-1] ^ f_r[DIFF_W-1];
      zdiv_r <= (f_r == '0);
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end

    if (cmd.finish) begin
      out_rsp_r.clip_status <= cmd.status;
      if (cmd.status == STATUS_INVISIBLE) begin
        out_rsp_r.clipped_start_x <= '0;
        out_rsp_r.clipped_start_y <= '0;
        out_rsp_r.clipped_end_x   <= '0;
        out_rsp_r.clipped_end_y   <= '0;
      end else begin
        out_rsp_r.clipped_start_x <= x0_r;
        out_rsp_r.clipped_start_y <= y0_r;
        out_rsp_r.clipped_end_x   <= x1_r;
        out_rsp_r.clipped_end_y   <= y1_r;
      end
    end
  end

  assign out_rsp = out_rsp_r;

endmodule

// File: rtl/line_segment_window_clip_top.sv
// Cohen-Sutherland segment clipper. A request (start high while busy is low) carries two
// endpoints; one result follows on out_rsp with out_valid high for exactly one cycle, and
// the receiver cannot stall it. A segment that is wholly inside, or any segment when the
// window is inverted, returns right after the first region check. Any other segment runs
// a decision and then, per edge move, setup, multiply, the shared 17-step restoring divider
// and an update, ending on a decision (at most eight moves, else it is reported invisible).
// busy stays high until the result is registered; a new request may be taken in the cycle
// the result is shown. The user writes window registers through cfg_we/cfg_index/cfg_wdata
// only while busy is low; the block does not enforce this. Unknown indexes are ignored.
module line_segment_window_clip_top
  import lswc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  in_req_t              in_req,
  output logic                 out_valid,
  output out_rsp_t             out_rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lswc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  lswc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_rsp   (out_rsp)
  );

endmodule
